// ===== sv/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP transmit segmenter package
// Shared constants, the per-state flag table and the command and status
// types that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int MAX_BURST = 64;
    localparam int CNT_W     = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

    localparam logic [3:0] ST_ESTABLISHED = 4'd4;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [15:0] MSS_RESET = 16'd1460;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQ  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG_SIZE = 1'b1;

    localparam logic OP_OUTPUT     = 1'b0;
    localparam logic OP_RETRANSMIT = 1'b1;

    function automatic logic [7:0] state_flags(input logic [3:0] st);
        logic [7:0] f;
        case (st)
            4'd0:    f = FL_RST | FL_ACK;
            4'd1:    f = 8'h00;
            4'd2:    f = FL_SYN;
            4'd3:    f = FL_SYN | FL_ACK;
            4'd4:    f = FL_ACK;
            4'd5:    f = FL_ACK;
            4'd6:    f = FL_FIN | FL_ACK;
            4'd7:    f = FL_FIN | FL_ACK;
            4'd8:    f = FL_FIN | FL_ACK;
            4'd9:    f = FL_ACK;
            4'd10:   f = FL_ACK;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    typedef struct packed {
        logic load;
        logic calc_flt;
        logic calc_room;
        logic calc_buf;
        logic calc_min;
        logic calc_len;
        logic decide;
        logic advance;
        logic build;
        logic push;
        logic push_last;
    } t_cmd;

    typedef struct packed {
        logic retx;
        logic drop;
        logic go;
        logic pend;
        logic final_seg;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/tts_in_if.sv =====
// ----------------------------------------------------------------------------
// Segmenter request channel
// Valid/ready channel that carries one output or retransmit request.
// ----------------------------------------------------------------------------
interface tts_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  conn_state;
    logic        ack_now;
    logic [31:0] unacked_seq;
    logic [31:0] peer_window;
    logic [31:0] congestion_window;
    logic [31:0] buffer_tail;
    logic        rexmit_running;
    logic        rtt_active;
    logic [31:0] retx_seq;

    modport source (
        output valid, opcode, conn_state, ack_now, unacked_seq, peer_window,
               congestion_window, buffer_tail, rexmit_running, rtt_active, retx_seq,
        input  ready
    );
    modport sink (
        input  valid, opcode, conn_state, ack_now, unacked_seq, peer_window,
               congestion_window, buffer_tail, rexmit_running, rtt_active, retx_seq,
        output ready
    );
endinterface

// ===== sv/tts_out_if.sv =====
// ----------------------------------------------------------------------------
// Segmenter descriptor channel
// Valid/ready channel that carries one segment descriptor.
// ----------------------------------------------------------------------------
interface tts_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] seg_seq;
    logic [7:0]  seg_flags;
    logic [15:0] seg_len;
    logic [31:0] buf_offset;
    logic        arm_timer;
    logic        start_rtt;
    logic [31:0] rtt_seq;
    logic        last;

    modport source (
        output valid, seg_seq, seg_flags, seg_len, buf_offset, arm_timer,
               start_rtt, rtt_seq, last,
        input  ready
    );
    modport sink (
        input  valid, seg_seq, seg_flags, seg_len, buf_offset, arm_timer,
               start_rtt, rtt_seq, last,
        output ready
    );
endinterface

// ===== sv/tts_dp.sv =====
// ----------------------------------------------------------------------------
// Segmenter datapath
// Holds the sequence state, the latched request, the per-segment arithmetic,
// one pending descriptor and the output register.
// ----------------------------------------------------------------------------
module tts_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tts_pkg::t_cmd                i_cmd,
    output tts_pkg::t_sts                o_sts,
    input  logic                         i_cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_opcode,
    input  logic [3:0]                   i_conn_state,
    input  logic                         i_ack_now,
    input  logic [31:0]                  i_unacked_seq,
    input  logic [31:0]                  i_peer_window,
    input  logic [31:0]                  i_congestion_window,
    input  logic [31:0]                  i_buffer_tail,
    input  logic                         i_rexmit_running,
    input  logic                         i_rtt_active,
    input  logic [31:0]                  i_retx_seq,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [31:0]                  o_seg_seq,
    output logic [7:0]                   o_seg_flags,
    output logic [15:0]                  o_seg_len,
    output logic [31:0]                  o_buf_offset,
    output logic                         o_arm_timer,
    output logic                         o_start_rtt,
    output logic [31:0]                  o_rtt_seq,
    output logic                         o_last
);

    // Configuration and connection state.
    logic [31:0] r_init_seq;
    logic [15:0] r_mss;
    logic [31:0] r_next_seq;
    logic [31:0] r_max_seq;

    // Latched request.
    logic        r_op;
    logic        r_est;
    logic [7:0]  r_flags;
    logic        r_force;
    logic [31:0] r_una;
    logic [31:0] r_win;
    logic [31:0] r_tail;
    logic        r_timer_on;
    logic        r_rtt_on;
    logic [31:0] r_rseq;

    // Per-segment working registers.
    logic [31:0] r_seq;
    logic [31:0] r_d;
    logic [31:0] r_flt;
    logic [31:0] r_room;
    logic [31:0] r_sent;
    logic [31:0] r_buf;
    logic [31:0] r_m;
    logic [15:0] r_len;
    logic        r_newctl;
    logic        r_adv;
    logic        r_arm;
    logic [tts_pkg::CNT_W-1:0] r_cnt;

    // Pending descriptor, released once the next decision is known or it is final.
    logic        r_pend;
    logic [31:0] r_p_seq;
    logic [7:0]  r_p_flags;
    logic [15:0] r_p_len;
    logic [31:0] r_p_off;
    logic        r_p_arm;
    logic        r_p_rtt;
    logic [31:0] r_p_rttseq;

    logic        r_ovalid;

    logic [32:0] n_room_diff;
    logic [32:0] n_buf_diff;
    logic [31:0] n_max_diff;
    logic        n_max_move;
    logic        n_start_rtt;
    logic        n_newctl;
    logic        n_out_free;
    logic        n_d_after;

    assign n_out_free  = !r_ovalid || i_out_ready;
    assign n_newctl    = ((r_flags & (tts_pkg::FL_SYN | tts_pkg::FL_FIN)) != 8'h00)
                         && (r_next_seq == r_max_seq);
    assign n_room_diff = {1'b0, r_win} - {1'b0, r_flt};
    assign n_buf_diff  = {1'b0, r_tail} - {1'b0, r_sent};
    assign n_d_after   = (r_d != 32'd0) && !r_d[31];
    assign n_max_diff  = r_next_seq - r_max_seq;
    assign n_max_move  = (r_op == tts_pkg::OP_OUTPUT) && r_adv
                         && (n_max_diff != 32'd0) && !n_max_diff[31];
    assign n_start_rtt = n_max_move && !r_rtt_on;

    always_comb begin
        o_sts.retx      = (r_op == tts_pkg::OP_RETRANSMIT);
        o_sts.drop      = (i_opcode == tts_pkg::OP_RETRANSMIT)
                          && (i_conn_state != tts_pkg::ST_ESTABLISHED);
        o_sts.go        = (r_len != 16'd0) || n_newctl || r_force;
        o_sts.pend      = r_pend;
        o_sts.final_seg = (r_op == tts_pkg::OP_RETRANSMIT) || (r_len == 16'd0)
                          || (r_cnt == tts_pkg::CNT_W'(tts_pkg::MAX_BURST - 1));
        o_sts.out_free  = n_out_free;
    end

    // Sequence state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_seq <= 32'd0;
            r_mss      <= tts_pkg::MSS_RESET;
            r_next_seq <= 32'd0;
            r_max_seq  <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tts_pkg::CFG_INITIAL_SEQ) begin
                    r_init_seq <= i_cfg_data;
                    r_next_seq <= i_cfg_data;
                    r_max_seq  <= i_cfg_data;
                end else if (i_cfg_idx == tts_pkg::CFG_MAX_SEG_SIZE) begin
                    r_mss <= i_cfg_data[15:0];
                end
            end
            if (i_cmd.advance) begin
                r_next_seq <= r_next_seq + {16'd0, r_len} + {31'd0, r_newctl};
            end
            if (i_cmd.build && n_max_move) begin
                r_max_seq <= r_next_seq;
            end
        end
    end

    // Request latch and segment arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_est      <= (i_conn_state == tts_pkg::ST_ESTABLISHED);
            r_flags    <= tts_pkg::state_flags(i_conn_state);
            r_force    <= i_ack_now;
            r_una      <= i_unacked_seq;
            r_win      <= (i_peer_window < i_congestion_window) ? i_peer_window
                                                                 : i_congestion_window;
            r_tail     <= i_buffer_tail;
            r_timer_on <= i_rexmit_running;
            r_rtt_on   <= i_rtt_active;
            r_rseq     <= i_retx_seq;
            r_adv      <= 1'b0;
            r_arm      <= 1'b0;
            r_cnt      <= '0;
        end
        if (i_cmd.calc_flt) begin
            r_seq <= (r_op == tts_pkg::OP_RETRANSMIT) ? r_rseq : r_next_seq;
            r_d   <= ((r_op == tts_pkg::OP_RETRANSMIT) ? r_rseq : r_next_seq) - r_init_seq;
            r_flt <= r_next_seq - r_una;
        end
        if (i_cmd.calc_room) begin
            // A retransmit is not bounded by the window.
            if (r_op == tts_pkg::OP_RETRANSMIT) begin
                r_room <= 32'hFFFF_FFFF;
            end else if (r_est && !n_room_diff[32]) begin
                r_room <= n_room_diff[31:0];
            end else begin
                r_room <= 32'd0;
            end
            r_sent <= n_d_after ? (r_d - 32'd1) : 32'd0;
        end
        if (i_cmd.calc_buf) begin
            r_buf <= n_buf_diff[32] ? 32'd0 : n_buf_diff[31:0];
        end
        if (i_cmd.calc_min) begin
            r_m <= (r_buf < r_room) ? r_buf : r_room;
        end
        if (i_cmd.calc_len) begin
            r_len <= (r_m > {16'd0, r_mss}) ? r_mss : r_m[15:0];
        end
        if (i_cmd.decide) begin
            r_newctl <= n_newctl;
        end
        if (i_cmd.advance) begin
            r_adv      <= (r_len != 16'd0) || r_newctl;
            r_arm      <= ((r_len != 16'd0) || r_newctl) && !r_timer_on;
            r_timer_on <= r_timer_on || (r_len != 16'd0) || r_newctl;
            r_force    <= 1'b0;
        end
        if (i_cmd.build) begin
            r_p_seq    <= r_seq;
            r_p_flags  <= r_flags;
            r_p_len    <= r_len;
            r_p_off    <= (r_len != 16'd0) ? (r_d - 32'd1) : 32'd0;
            r_p_arm    <= r_arm;
            r_p_rtt    <= n_start_rtt;
            r_p_rttseq <= n_start_rtt ? r_seq : 32'd0;
            r_cnt      <= r_cnt + tts_pkg::CNT_W'(1);
            if (n_start_rtt) begin
                r_rtt_on <= 1'b1;
            end
        end
        if (i_cmd.push) begin
            o_seg_seq    <= r_p_seq;
            o_seg_flags  <= r_p_flags;
            o_seg_len    <= r_p_len;
            o_buf_offset <= r_p_off;
            o_arm_timer  <= r_p_arm;
            o_start_rtt  <= r_p_rtt;
            o_rtt_seq    <= r_p_rttseq;
            o_last       <= i_cmd.push_last;
        end
    end

    // Control flags of the pending slot and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.build) begin
                r_pend <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

// ===== sv/tts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segmenter sequencer
// State machine that steps the datapath through each segment of a request
// and hands every descriptor to the output once its last flag is known.
// ----------------------------------------------------------------------------
module tts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tts_pkg::t_sts i_sts,
    output tts_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FLT  = 4'd1;
    localparam logic [3:0] S_ROOM = 4'd2;
    localparam logic [3:0] S_BUF  = 4'd3;
    localparam logic [3:0] S_MIN  = 4'd4;
    localparam logic [3:0] S_LEN  = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_ADV  = 4'd7;
    localparam logic [3:0] S_BLD  = 4'd8;
    localparam logic [3:0] S_PUSH = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_push_last;
    logic       n_push_last;
    logic       n_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign n_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_push_last = r_push_last;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = n_accept;
                if (n_accept && !i_sts.drop) begin
                    n_state = S_FLT;
                end
            end
            S_FLT: begin
                o_cmd.calc_flt = 1'b1;
                n_state        = S_ROOM;
            end
            S_ROOM: begin
                o_cmd.calc_room = 1'b1;
                n_state         = S_BUF;
            end
            S_BUF: begin
                o_cmd.calc_buf = 1'b1;
                n_state        = S_MIN;
            end
            S_MIN: begin
                o_cmd.calc_min = 1'b1;
                n_state        = S_LEN;
            end
            S_LEN: begin
                o_cmd.calc_len = 1'b1;
                n_state        = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                if (i_sts.retx) begin
                    n_state = S_BLD;
                end else if (i_sts.go) begin
                    // The held descriptor is not the last one of the burst.
                    if (i_sts.pend) begin
                        n_state     = S_PUSH;
                        n_push_last = 1'b0;
                    end else begin
                        n_state = S_ADV;
                    end
                end else if (i_sts.pend) begin
                    n_state     = S_PUSH;
                    n_push_last = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_BLD;
            end
            S_BLD: begin
                o_cmd.build = 1'b1;
                if (i_sts.final_seg) begin
                    n_state     = S_PUSH;
                    n_push_last = 1'b1;
                end else begin
                    n_state = S_FLT;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = r_push_last;
                    n_state         = r_push_last ? S_IDLE : S_ADV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_push_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_push_last <= n_push_last;
        end
    end

endmodule

// ===== sv/tcp_transmit_segmenter.sv =====
// Each output segment passes eight sequencer steps (a retransmit skips the
// advance step). A descriptor is held until the next segment's decision
// unless final, then waits in the push state until the output is free.
// A new request is taken only when the previous one is done.
// Synchronous active-low reset: sequences and initial sequence clear to zero,
// segment size returns to 1460 and the output goes empty.
// ----------------------------------------------------------------------------
// TCP transmit segmenter
// Transmit decision engine of a TCP sender: turns output and retransmit
// requests into bursts of segment descriptors.
// ----------------------------------------------------------------------------
module tcp_transmit_segmenter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    tts_in_if.sink                        i_in,
    tts_out_if.source                     o_out
);

    tts_pkg::t_cmd w_cmd;
    tts_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_in.ready = w_in_ready;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tts_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_opcode            (i_in.opcode),
        .i_conn_state        (i_in.conn_state),
        .i_ack_now           (i_in.ack_now),
        .i_unacked_seq       (i_in.unacked_seq),
        .i_peer_window       (i_in.peer_window),
        .i_congestion_window (i_in.congestion_window),
        .i_buffer_tail       (i_in.buffer_tail),
        .i_rexmit_running    (i_in.rexmit_running),
        .i_rtt_active        (i_in.rtt_active),
        .i_retx_seq          (i_in.retx_seq),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_seg_seq           (o_out.seg_seq),
        .o_seg_flags         (o_out.seg_flags),
        .o_seg_len           (o_out.seg_len),
        .o_buf_offset        (o_out.buf_offset),
        .o_arm_timer         (o_out.arm_timer),
        .o_start_rtt         (o_out.start_rtt),
        .o_rtt_seq           (o_out.rtt_seq),
        .o_last              (o_out.last)
    );

endmodule
